// ----- hdl/gndp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the greedy nearest-defect pairing block.
// Holds the sequencer state type, the result word type and fixed constants.
package gndp_pkg;

    // Width of the index fields on the result port
    localparam int OUT_W = 16;

    // Widest distance that still counts as a candidate (exclusive)
    localparam logic [29:0] DIST_LIMIT = 30'd1000000000;
    localparam int LIMIT_W = 30;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_NEXT_I,
        ST_GET_A,
        ST_SCAN,
        ST_PAIR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [OUT_W-1:0] first_index;
        logic [OUT_W-1:0] second_index;
        logic             pair_valid;
        logic             last_pair;
        logic             overflow;
    } result_t;

endpackage

// ----- hdl/greedy_nearest_defect_pairing.sv -----
`timescale 1ns / 1ps
// Greedy nearest-defect pairing, top level: store, sequencer, output register.
// Uses gndp_pkg, gndp_store and gndp_ctrl.
//
// Usage: send defect indices one word per cycle on the input channel
// (in_valid/in_ready), the final one of a list with last_defect set.
// After the last word in_ready drops while the list is paired; pairs come out
// on the output channel (out_valid/out_ready) in the order they form, the
// final one with last_pair set. A list with no pair gives one word with
// pair_valid clear.
// Words beyond MAX_DEFECTS are dropped and overflow is set on every result.
// During pairing the sequencer steps past already matched defects; for each
// open defect i it scans the later defects in turn: the single distance
// unit compares one candidate per cycle from the one read port of the store.
// A closing step hands out the final result.
// A result waits in the output register while the receiver stalls; the
// sequencer stops only when it has a new word to hand over. Loading of the
// next list starts while the final result still waits. Reset empties the
// list and the output register; the store needs no clearing.
module greedy_nearest_defect_pairing #(
    parameter int MAX_DEFECTS = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gndp_pkg::OUT_W-1:0]    defect_index,
    input  logic                          last_defect,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gndp_pkg::OUT_W-1:0]    first_index,
    output logic [gndp_pkg::OUT_W-1:0]    second_index,
    output logic                          pair_valid,
    output logic                          last_pair,
    output logic                          overflow
);

    import gndp_pkg::*;

    localparam int AW = $clog2(MAX_DEFECTS);
    localparam int CW = $clog2(MAX_DEFECTS + 1);

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [INDEX_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [INDEX_BITS-1:0] rd_data;
    logic                  emit_valid;
    result_t               emit_word;
    logic                  out_free;

    logic                  out_valid_reg, out_valid_next;
    result_t               out_word_reg;

    gndp_store #(
        .DEPTH (MAX_DEFECTS),
        .IW    (INDEX_BITS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gndp_ctrl #(
        .MAX_DEFECTS (MAX_DEFECTS),
        .IW          (INDEX_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .defect_index (defect_index),
        .last_defect  (last_defect),
        .out_free     (out_free),
        .emit_valid   (emit_valid),
        .emit_word    (emit_word),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // Output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (emit_valid)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new result word
    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign out_valid    = out_valid_reg;
    assign first_index  = out_word_reg.first_index;
    assign second_index = out_word_reg.second_index;
    assign pair_valid   = out_word_reg.pair_valid;
    assign last_pair    = out_word_reg.last_pair;
    assign overflow     = out_word_reg.overflow;

endmodule

// ----- hdl/gndp_store.sv -----
`timescale 1ns / 1ps
// Defect index store: one write port and one read port with registered data.
// Depends on nothing outside this file.
module gndp_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 16,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [IW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [IW-1:0] rd_data
);

    logic [IW-1:0] mem [DEPTH];
    logic [IW-1:0] rd_data_reg;

    // Write one entry while loading
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read every cycle, data is registered and shows up in the next cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/gndp_cmp.sv -----
`timescale 1ns / 1ps
// Shared distance unit: absolute difference of two indices and a compare
// against the best distance so far. Depends on nothing outside this file.
module gndp_cmp #(
    parameter int IW = 16,
    parameter int DW = 30
) (
    input  logic [IW-1:0] a,
    input  logic [IW-1:0] b,
    input  logic [DW-1:0] best,
    output logic [DW-1:0] gap,
    output logic          better
);

    logic [IW-1:0] diff;

    // Subtract the smaller from the larger
    assign diff   = (a >= b) ? (a - b) : (b - a);
    assign gap    = DW'(diff);
    // Strict compare, so an earlier candidate keeps a tie
    assign better = (gap < best);

endmodule

// ----- hdl/gndp_ctrl.sv -----
`timescale 1ns / 1ps
// Load and pairing sequencer: collects defects, scans for nearest partners
// with the shared distance unit, and hands out result words. Uses gndp_pkg.
module gndp_ctrl #(
    parameter int MAX_DEFECTS = 64,
    parameter int IW          = 16,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gndp_pkg::OUT_W-1:0]      defect_index,
    input  logic                            last_defect,
    input  logic                            out_free,
    output logic                            emit_valid,
    output gndp_pkg::result_t               emit_word,
    output logic                            wr_en,
    output logic [AW-1:0]                   wr_addr,
    output logic [IW-1:0]                   wr_data,
    output logic [AW-1:0]                   rd_addr,
    input  logic [IW-1:0]                   rd_data
);

    import gndp_pkg::*;

    localparam int DW = (IW > LIMIT_W) ? IW : LIMIT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DEFECTS);

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [MAX_DEFECTS-1:0] matched_reg, matched_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   found_reg, found_next;

    logic [AW-1:0]          cmp_j_reg, cmp_j_next;
    logic [AW-1:0]          best_j_reg, best_j_next;
    logic [DW-1:0]          best_dist_reg, best_dist_next;
    logic [IW-1:0]          best_val_reg, best_val_next;
    logic [IW-1:0]          a_reg, a_next;
    logic [IW-1:0]          pend_first_reg, pend_first_next;
    logic [IW-1:0]          pend_second_reg, pend_second_next;

    logic [DW-1:0]          gap;
    logic                   better;
    logic [IW+OUT_W-1:0]    idx_ext;

    // Fit a stored index onto the result field width
    function automatic logic [OUT_W-1:0] to_out(input logic [IW-1:0] v);
        logic [OUT_W+IW-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        return ext[OUT_W-1:0];
    endfunction

    // Keep only the low index bits of an incoming defect
    assign idx_ext = {{IW{1'b0}}, defect_index};

    gndp_cmp #(
        .IW (IW),
        .DW (DW)
    ) u_cmp (
        .a      (a_reg),
        .b      (rd_data),
        .best   (best_dist_reg),
        .gap    (gap),
        .better (better)
    );

    // Next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        matched_next     = matched_reg;
        pend_valid_next  = pend_valid_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        cmp_valid_next   = cmp_valid_reg;
        found_next       = found_reg;
        cmp_j_next       = cmp_j_reg;
        best_j_next      = best_j_reg;
        best_dist_next   = best_dist_reg;
        best_val_next    = best_val_reg;
        a_next           = a_reg;
        pend_first_next  = pend_first_reg;
        pend_second_next = pend_second_reg;

        in_ready   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = idx_ext[IW-1:0];
        rd_addr    = j_reg[AW-1:0];
        emit_valid = 1'b0;
        emit_word  = '0;

        case (state_reg)
            ST_LOAD:
            begin
                // Store the word, or drop it once the store is full
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg != MAX_CNT)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_defect)
                    begin
                        i_next     = '0;
                        state_next = ST_NEXT_I;
                    end
                end
            end

            ST_NEXT_I:
            begin
                // Skip matched defects, fetch the next open one
                rd_addr = i_reg[AW-1:0];
                if (i_reg >= count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (matched_reg[i_reg[AW-1:0]])
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_GET_A;
                end
            end

            ST_GET_A:
            begin
                // Latch the reference index and start the scan
                a_next         = rd_data;
                j_next         = i_reg + CW'(1);
                best_dist_next = DW'(DIST_LIMIT);
                found_next     = 1'b0;
                cmp_valid_next = 1'b0;
                state_next     = ST_SCAN;
            end

            ST_SCAN:
            begin
                // Compare the candidate read last cycle
                if (cmp_valid_reg && better)
                begin
                    best_dist_next = gap;
                    best_j_next    = cmp_j_reg;
                    best_val_next  = rd_data;
                    found_next     = 1'b1;
                end
                // Issue the next candidate read
                if (j_reg < count_reg)
                begin
                    cmp_valid_next = !matched_reg[j_reg[AW-1:0]];
                    cmp_j_next     = j_reg[AW-1:0];
                    j_next         = j_reg + CW'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg)
                    begin
                        state_next = ST_PAIR;
                    end
                end
            end

            ST_PAIR:
            begin
                // Hold one pair back so the final one can carry the last mark
                if (!found_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_NEXT_I;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        emit_valid             = 1'b1;
                        emit_word.first_index  = to_out(pend_first_reg);
                        emit_word.second_index = to_out(pend_second_reg);
                        emit_word.pair_valid   = 1'b1;
                        emit_word.last_pair    = 1'b0;
                        emit_word.overflow     = ovf_reg;
                    end
                    pend_valid_next                 = 1'b1;
                    pend_first_next                 = a_reg;
                    pend_second_next                = best_val_reg;
                    matched_next[i_reg[AW-1:0]]     = 1'b1;
                    matched_next[best_j_reg]        = 1'b1;
                    i_next                          = i_reg + CW'(1);
                    state_next                      = ST_NEXT_I;
                end
            end

            ST_FINISH:
            begin
                // Send the held pair marked last, or the empty result
                if (out_free)
                begin
                    emit_valid          = 1'b1;
                    emit_word.last_pair = 1'b1;
                    emit_word.overflow  = ovf_reg;
                    if (pend_valid_reg)
                    begin
                        emit_word.first_index  = to_out(pend_first_reg);
                        emit_word.second_index = to_out(pend_second_reg);
                        emit_word.pair_valid   = 1'b1;
                    end
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    matched_next    = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            matched_reg    <= '0;
            pend_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            matched_reg    <= matched_next;
            pend_valid_reg <= pend_valid_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmp_j_reg       <= cmp_j_next;
        best_j_reg      <= best_j_next;
        best_dist_reg   <= best_dist_next;
        best_val_reg    <= best_val_next;
        a_reg           <= a_next;
        pend_first_reg  <= pend_first_next;
        pend_second_reg <= pend_second_next;
    end

endmodule

// ----- hdl/gndp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the pairing block, attached by a bind statement.
// Depends on gndp_pkg and the top level greedy_nearest_defect_pairing.
module gndp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       last_defect,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [gndp_pkg::OUT_W-1:0] first_index,
    input logic [gndp_pkg::OUT_W-1:0] second_index,
    input logic                       pair_valid,
    input logic                       last_pair
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_index)
            && $stable(second_index) && $stable(pair_valid) && $stable(last_pair))
    else $error("result word changed while stalled");

    // The empty result is always the final one and carries zero indices
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pair_valid |-> last_pair && first_index == '0 && second_index == '0)
    else $error("empty result malformed");

    // Loading continues after a word that is not the last of its list
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_defect |=> in_ready)
    else $error("input stalled in the middle of a list");

    // Pairing starts right after the last word of a list
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_defect |=> !in_ready)
    else $error("input still open after the last word");

endmodule

bind greedy_nearest_defect_pairing gndp_checker u_gndp_checker (.*);

// ----- dv/gndp_pair_checker.sv -----
`timescale 1ns / 1ps
// Checker for the greedy nearest-defect pairing block: predicts the pair words.
// It watches both channels and compares each accepted result word with the prediction.
// Depends on gndp_pkg for the result word type and the distance limit.
module gndp_pair_checker #(
    parameter int MAX_DEFECTS = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [gndp_pkg::OUT_W-1:0] defect_index,
    input  logic                       last_defect,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [gndp_pkg::OUT_W-1:0] first_index,
    input  logic [gndp_pkg::OUT_W-1:0] second_index,
    input  logic                       pair_valid,
    input  logic                       last_pair,
    input  logic                       overflow,
    output int                         errors,
    output int                         waiting,
    output int                         answered
);

    import gndp_pkg::*;

    localparam logic [OUT_W-1:0] IDX_MASK =
        (INDEX_BITS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((1 << INDEX_BITS) - 1);

    // Shadow copy of the list being loaded
    logic [OUT_W-1:0] list_idx [MAX_DEFECTS];
    int               list_len;
    logic             list_ovf;

    // Pair words still owed by the block, oldest first
    result_t          pending_pairs [$];
    int               err_count;
    int               lists_answered;

    // Pair the loaded list greedily and queue one word per pair
    function automatic void form_pairs();
        bit      taken [MAX_DEFECTS];
        result_t found [MAX_DEFECTS/2];
        result_t w;
        int      npairs;
        int      best_j;
        int      best_d;
        int      a;
        int      b;
        int      d;
        npairs = 0;
        foreach (taken[k]) taken[k] = 1'b0;
        for (int i = 0; i < list_len; i++) begin
            if (taken[i]) continue;
            best_j = i;
            best_d = int'(DIST_LIMIT);
            for (int j = i + 1; j < list_len; j++) begin
                if (taken[j]) continue;
                a = int'(list_idx[i]);
                b = int'(list_idx[j]);
                d = (a > b) ? a - b : b - a;
                // strict compare: the earlier candidate keeps a tie
                if (d < best_d) begin
                    best_d = d;
                    best_j = j;
                end
            end
            if (best_j != i && npairs < MAX_DEFECTS / 2) begin
                found[npairs].first_index  = list_idx[i];
                found[npairs].second_index = list_idx[best_j];
                found[npairs].pair_valid   = 1'b1;
                found[npairs].last_pair    = 1'b0;
                found[npairs].overflow     = list_ovf;
                taken[i]      = 1'b1;
                taken[best_j] = 1'b1;
                npairs++;
            end
        end
        // No pair at all: one empty word closes the list
        if (npairs == 0) begin
            w.first_index  = '0;
            w.second_index = '0;
            w.pair_valid   = 1'b0;
            w.last_pair    = 1'b1;
            w.overflow     = list_ovf;
            pending_pairs.insert(pending_pairs.size(), w);
        end
        for (int k = 0; k < npairs; k++) begin
            w = found[k];
            w.last_pair = (k == npairs - 1);
            pending_pairs.insert(pending_pairs.size(), w);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            list_len       = 0;
            list_ovf       = 1'b0;
            err_count      = 0;
            lists_answered = 0;
            pending_pairs.delete();
            errors   <= 0;
            waiting  <= 0;
            answered <= 0;
        end
        else
        begin
            // Compare an accepted result word with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (pending_pairs.size() == 0)
                begin
                    $display("%0t: no pair word expected, actual first %0d second %0d",
                             $time, first_index, second_index);
                    err_count++;
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    check_field("first_index", want.first_index, first_index);
                    check_field("second_index", want.second_index, second_index);
                    check_field("pair_valid", want.pair_valid, pair_valid);
                    check_field("last_pair", want.last_pair, last_pair);
                    check_field("overflow", want.overflow, overflow);
                end
                if (last_pair) lists_answered++;
            end

            // Store an accepted defect word; drop it once the store is full
            if (in_valid && in_ready)
            begin
                if (list_len < MAX_DEFECTS)
                begin
                    list_idx[list_len] = defect_index & IDX_MASK;
                    list_len++;
                end
                else
                begin
                    list_ovf = 1'b1;
                end
                if (last_defect)
                begin
                    form_pairs();
                    list_len = 0;
                    list_ovf = 1'b0;
                end
            end

            errors   <= err_count;
            waiting  <= pending_pairs.size();
            answered <= lists_answered;
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Top of the pairing testbench: clock, reset, defect word stimulus and verdict.
// Needs gndp_pkg, greedy_nearest_defect_pairing and gndp_pair_checker.
module tb;
    import gndp_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int WORD_TARGET = 210;
    localparam int TAIL_CYCLES = 64;

    typedef enum int {
        MIX_SPREAD,
        MIX_CLUSTER,
        MIX_NARROW
    } mix_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [OUT_W-1:0] defect_index;
    logic             last_defect;
    logic             out_valid;
    logic             out_ready;
    logic [OUT_W-1:0] first_index;
    logic [OUT_W-1:0] second_index;
    logic             pair_valid;
    logic             last_pair;
    logic             overflow;

    int               errors;
    int               waiting;
    int               answered;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               words_sent;
    int               lists_sent;
    logic [OUT_W-1:0] list_words [$];

    greedy_nearest_defect_pairing u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .defect_index (defect_index),
        .last_defect  (last_defect),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_index  (first_index),
        .second_index (second_index),
        .pair_valid   (pair_valid),
        .last_pair    (last_pair),
        .overflow     (overflow)
    );

    gndp_pair_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .defect_index (defect_index),
        .last_defect  (last_defect),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_index  (first_index),
        .second_index (second_index),
        .pair_valid   (pair_valid),
        .last_pair    (last_pair),
        .overflow     (overflow),
        .errors       (errors),
        .waiting      (waiting),
        .answered     (answered)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the receiver at random
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hand over one defect word, with random gaps ahead of it
    task automatic send_word(input logic [OUT_W-1:0] d, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        defect_index <= d;
        last_defect  <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Send the staged list, marking its final word
    task automatic send_list();
        for (int k = 0; k < list_words.size(); k++)
            send_word(list_words[k], k == list_words.size() - 1);
        lists_sent++;
    endtask

    // Hold the sender until every list sent so far has been answered
    task automatic drain_results();
        in_valid <= 1'b0;
        while (answered != lists_sent) @(posedge clk);
    endtask

    // Stage a random list; clustered and narrow mixes make ties and duplicates
    task automatic make_random_list(input int len);
        mix_t             mix;
        logic [OUT_W-1:0] base;
        mix  = mix_t'($urandom_range(2));
        base = OUT_W'($urandom);
        list_words.delete();
        repeat (len)
        begin
            case (mix)
                MIX_SPREAD:
                    list_words.insert(list_words.size(), OUT_W'($urandom));
                MIX_CLUSTER:
                    list_words.insert(list_words.size(), base + OUT_W'($urandom_range(8)));
                default:
                    list_words.insert(list_words.size(), OUT_W'($urandom_range(15)));
            endcase
        end
    endtask

    initial
    begin
        int len;
        bit ovf_done;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        defect_index <= '0;
        last_defect  <= 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 74;
        words_sent    = 0;
        lists_sent    = 0;
        ovf_done      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single defect: no pair forms
        list_words = '{16'd0};
        send_list();
        // Extremes of the index range
        list_words = '{16'd0, 16'hFFFF};
        send_list();
        list_words = '{16'hFFFF, 16'd0, 16'hFFFF};
        send_list();
        // Equal distance on both sides: the earlier candidate wins, odd one left over
        list_words = '{16'd10, 16'd5, 16'd15};
        send_list();
        // Skip already matched defects
        list_words = '{16'd100, 16'd200, 16'd101, 16'd199, 16'd150};
        send_list();
        // Duplicate indices
        list_words = '{16'd7, 16'd7, 16'd7, 16'd7};
        send_list();
        list_words = '{16'h5555, 16'hAAAA};
        send_list();
        drain_results();

        // Random lists over three idling phases
        while (words_sent < WORD_TARGET || !ovf_done)
        begin
            if (words_sent < 90)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 74;
            end
            else if (words_sent < 150)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Fill the store and drop the final word, last mark included
            if (!ovf_done && words_sent >= 150)
            begin
                len      = STORE_DEPTH + 1;
                ovf_done = 1'b1;
            end
            else if (words_sent + STORE_DEPTH + 6 < 150 && $urandom_range(99) < 4)
                len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 2);
            else
                len = $urandom_range(12, 1);
            make_random_list(len);
            send_list();
            if ($urandom_range(99) < 10) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
